// ===== sv/multilevel_priority_queue_core_macros.svh =====
// Assertion macros for the multilevel priority queue checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MULTILEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, off while reset is applied
`define MLPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is applied
`define MLPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mlpq_pkg.sv =====
// Shared types and codes for the multilevel priority queue.
// No dependencies; imported by the core and the checker.
package mlpq_pkg;

    localparam int ID_W      = 16;
    localparam int LVL_W     = 8;
    localparam int CNT_OUT_W = 5;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_MOVE   = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DESC,
        S_EVAL,
        S_RMV,
        S_MV_RD,
        S_MV_WR,
        S_MV_END
    } state_t;

    // One request
    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  item_id;
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] target_level;
    } in_item_t;

    // One response
    typedef struct packed {
        logic                 ok;
        logic [CNT_OUT_W-1:0] level_count;
        logic [ID_W-1:0]      removed_id;
    } out_item_t;

endpackage

// ===== sv/mlpq_entry_ram.sv =====
// Entry store of the queue: simple dual-port RAM, one write and one read port.
// Read data is registered. No package dependency.
module mlpq_entry_ram #(
    parameter int WORDS  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/multilevel_priority_queue_core.sv =====
// Top level of the multilevel priority queue: sequencer, level descriptors.
// Depends on mlpq_pkg and mlpq_entry_ram.
//
// LEVELS FIFO queues of DEPTH ids each; a higher level number is served first
// by remove. A request transfers at a clock edge with start high and busy low;
// its single response shows on rsp for one cycle with done high, and a new
// request may transfer in that same cycle. Every request first reads its level
// descriptors and is then evaluated; remove then takes the id from the entry RAM
// (unless every level is empty), and a move copies at most DEPTH ids to the
// target, each with one read and one write of the single entry RAM, before it
// writes the target descriptor. Ids that do not fit in the target are dropped.
// No clearing pass: per-level descriptor valid bits clear at reset.
module multilevel_priority_queue_core #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mlpq_pkg::in_item_t   req,
    output logic                 busy,
    output logic                 done,
    output mlpq_pkg::out_item_t  rsp
);
    import mlpq_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(LEVELS * DEPTH);

    // head/tail slot and fill count of one level
    typedef struct packed {
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
        logic [CW-1:0] cnt;
    } desc_t;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ent_addr(input logic [LW-1:0] lvl,
                                               input logic [SW-1:0] slot);
        logic [AW-1:0] base;
        base     = AW'(AW'(lvl) * AW'(DEPTH));
        ent_addr = base + AW'(slot);
    endfunction

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [LW-1:0]     src_reg, src_next;
    logic [LW-1:0]     tgt_reg, tgt_next;
    logic              src_ok_reg, src_ok_next;
    logic              tgt_ok_reg, tgt_ok_next;
    logic [SW-1:0]     rd_slot_reg, rd_slot_next;
    logic [SW-1:0]     wr_slot_reg, wr_slot_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     mv_n_reg, mv_n_next;
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [LEVELS-1:0] desc_vld_reg;
    logic              done_reg, done_next;
    out_item_t         rsp_reg, rsp_next;

    // descriptor memory
    desc_t             desc_mem [LEVELS];
    desc_t             src_rd_reg, tgt_rd_reg;
    logic              src_vld_reg, tgt_vld_reg;
    logic              desc_re;
    logic              desc_we;
    logic [LW-1:0]     desc_waddr;
    desc_t             desc_wdata;

    // entry RAM port
    logic              ent_we, ent_re;
    logic [AW-1:0]     ent_waddr, ent_raddr;
    logic [ID_W-1:0]   ent_wdata, ent_rdata;

    // evaluation helpers
    desc_t             sdesc, tdesc;
    logic              req_lvl_ok, req_tgt_ok;
    logic [LW-1:0]     top_lvl;
    logic              src_full;
    logic [CW-1:0]     room;
    logic [CW-1:0]     mv_n;
    logic              mv_go;

    mlpq_entry_ram #(
        .WORDS  (LEVELS * DEPTH),
        .ADDR_W (AW),
        .DATA_W (ID_W)
    ) u_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // highest non-empty level
    always_comb
    begin
        top_lvl = '0;
        for (int k = 0; k < LEVELS; k++)
        begin
            if (nonempty_reg[k])
            begin
                top_lvl = LW'(k);
            end
        end
    end

    assign req_lvl_ok = (req.level < LVL_W'(LEVELS));
    assign req_tgt_ok = (req.target_level < LVL_W'(LEVELS));

    // descriptors as read; never-written levels read empty
    assign sdesc    = src_vld_reg ? src_rd_reg : '0;
    assign tdesc    = tgt_vld_reg ? tgt_rd_reg : '0;
    assign src_full = (sdesc.cnt == CW'(DEPTH));
    assign room     = CW'(DEPTH) - tdesc.cnt;
    assign mv_n     = (sdesc.cnt < room) ? sdesc.cnt : room;
    assign mv_go    = src_ok_reg && tgt_ok_reg && (src_reg != tgt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DESC;
                end
            end
            S_DESC:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                unique case (op_reg)
                    OP_ADD:    state_next = S_IDLE;
                    OP_COUNT:  state_next = S_IDLE;
                    OP_REMOVE: state_next = src_ok_reg ? S_RMV : S_IDLE;
                    OP_MOVE:   state_next = (mv_go && mv_n != '0) ? S_MV_RD : S_IDLE;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_RMV:
            begin
                state_next = S_IDLE;
            end
            S_MV_RD:
            begin
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                state_next = (left_reg == CW'(1)) ? S_MV_END : S_MV_RD;
            end
            S_MV_END:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        op_next       = op_reg;
        id_next       = id_reg;
        src_next      = src_reg;
        tgt_next      = tgt_reg;
        src_ok_next   = src_ok_reg;
        tgt_ok_next   = tgt_ok_reg;
        rd_slot_next  = rd_slot_reg;
        wr_slot_next  = wr_slot_reg;
        left_next     = left_reg;
        mv_n_next     = mv_n_reg;
        nonempty_next = nonempty_reg;
        rsp_next      = rsp_reg;
        desc_re       = 1'b0;
        desc_we       = 1'b0;
        desc_waddr    = src_reg;
        desc_wdata    = sdesc;
        ent_we        = 1'b0;
        ent_re        = 1'b0;
        ent_waddr     = ent_addr(tgt_reg, wr_slot_reg);
        ent_raddr     = ent_addr(src_reg, rd_slot_reg);
        ent_wdata     = ent_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                // capture the request; remove picks its level here
                if (start)
                begin
                    op_next     = req.op;
                    id_next     = req.item_id;
                    tgt_ok_next = req_tgt_ok;
                    tgt_next    = req_tgt_ok ? req.target_level[LW-1:0] : '0;
                    if (req.op == OP_REMOVE)
                    begin
                        src_ok_next = |nonempty_reg;
                        src_next    = top_lvl;
                    end
                    else
                    begin
                        src_ok_next = req_lvl_ok;
                        src_next    = req_lvl_ok ? req.level[LW-1:0] : '0;
                    end
                end
            end
            S_DESC:
            begin
                desc_re = 1'b1;
            end
            S_EVAL:
            begin
                rsp_next = '0;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (src_ok_reg && !src_full)
                        begin
                            ent_we                 = 1'b1;
                            ent_waddr              = ent_addr(src_reg, sdesc.tail);
                            ent_wdata              = id_reg;
                            desc_we                = 1'b1;
                            desc_wdata.tail        = slot_inc(sdesc.tail);
                            desc_wdata.cnt         = sdesc.cnt + 1'b1;
                            nonempty_next[src_reg] = 1'b1;
                            rsp_next.ok            = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (src_ok_reg)
                        begin
                            ent_re          = 1'b1;
                            ent_raddr       = ent_addr(src_reg, sdesc.head);
                            desc_we         = 1'b1;
                            desc_wdata.head = slot_inc(sdesc.head);
                            desc_wdata.cnt  = sdesc.cnt - 1'b1;
                            if (sdesc.cnt == CW'(1))
                            begin
                                nonempty_next[src_reg] = 1'b0;
                            end
                        end
                    end
                    OP_COUNT:
                    begin
                        if (src_ok_reg)
                        begin
                            rsp_next.ok          = 1'b1;
                            rsp_next.level_count = CNT_OUT_W'(sdesc.cnt);
                        end
                    end
                    OP_MOVE:
                    begin
                        rsp_next.ok = src_ok_reg && tgt_ok_reg;
                        if (mv_go)
                        begin
                            // source ends empty at once; target written at the end of a copy
                            desc_we                = 1'b1;
                            desc_wdata.head        = sdesc.tail;
                            desc_wdata.cnt         = '0;
                            nonempty_next[src_reg] = 1'b0;
                            if (mv_n != '0)
                            begin
                                nonempty_next[tgt_reg] = 1'b1;
                            end
                            rd_slot_next = sdesc.head;
                            wr_slot_next = tdesc.tail;
                            left_next    = mv_n;
                            mv_n_next    = mv_n;
                        end
                    end
                    default:
                    begin
                        rsp_next = '0;
                    end
                endcase
            end
            S_RMV:
            begin
                rsp_next.removed_id = ent_rdata;
                rsp_next.ok         = 1'b1;
            end
            S_MV_RD:
            begin
                ent_re       = 1'b1;
                rd_slot_next = slot_inc(rd_slot_reg);
            end
            S_MV_WR:
            begin
                ent_we       = 1'b1;
                wr_slot_next = slot_inc(wr_slot_reg);
                left_next    = left_reg - 1'b1;
            end
            S_MV_END:
            begin
                desc_we         = 1'b1;
                desc_waddr      = tgt_reg;
                desc_wdata.head = tdesc.head;
                desc_wdata.tail = wr_slot_reg;
                desc_wdata.cnt  = tdesc.cnt + mv_n_reg;
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    assign done_next = (state_next == S_IDLE) && (state_reg != S_IDLE);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            nonempty_reg <= '0;
            desc_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            nonempty_reg <= nonempty_next;
            if (desc_we)
            begin
                desc_vld_reg[desc_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        src_reg     <= src_next;
        tgt_reg     <= tgt_next;
        src_ok_reg  <= src_ok_next;
        tgt_ok_reg  <= tgt_ok_next;
        rd_slot_reg <= rd_slot_next;
        wr_slot_reg <= wr_slot_next;
        left_reg    <= left_next;
        mv_n_reg    <= mv_n_next;
        rsp_reg     <= rsp_next;
    end

    // descriptor memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[desc_waddr] <= desc_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_re)
        begin
            src_rd_reg  <= desc_mem[src_reg];
            tgt_rd_reg  <= desc_mem[tgt_reg];
            src_vld_reg <= desc_vld_reg[src_reg];
            tgt_vld_reg <= desc_vld_reg[tgt_reg];
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== sv/mlpq_checker.sv =====
// Port-level checks for multilevel_priority_queue_core, attached by bind.
// Depends on mlpq_pkg and multilevel_priority_queue_core_macros.svh.
`include "multilevel_priority_queue_core_macros.svh"

module mlpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input mlpq_pkg::out_item_t rsp
);
    import mlpq_pkg::*;

    // an accepted request occupies the block
    `MLPQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")

    // a response ends the work: busy drops exactly with done
    `MLPQ_ASSERT_IMP(a_fell_done, $fell(busy), done, "busy dropped without a response")
    `MLPQ_ASSERT_IMP(a_done_idle, done, !busy, "response shown while still busy")

    // a failed operation reports no count and no id
    `MLPQ_ASSERT_IMP(a_fail_zero, done && !rsp.ok,
        rsp.level_count == '0 && rsp.removed_id == '0, "failed response carries data")

endmodule

bind multilevel_priority_queue_core mlpq_checker u_mlpq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
